FILE: design/fwfr_pkg.sv
// Shared constants and types for the four-way frame receiver.
// Used by the top level, the CRC update unit and the port checker.
package fwfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned COUNT_W  = 9;

    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h2F;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_TOP     = 16'h8000;

    localparam logic KIND_PARAM = 1'b0;
    localparam logic KIND_END   = 1'b1;

endpackage

FILE: design/four_way_frame_receiver_crc16.sv
// Top level of the four-way host frame receiver with CRC-16/XMODEM check.
// Depends on fwfr_pkg and fwfr_crc16.
//
// Takes one received byte per item and deframes escape/command/address/length/
// parameter/CRC frames. Each parameter byte yields one result with its index,
// and the CRC low byte yields a frame-end result with the match flag; all other
// bytes yield none. One byte is accepted every clock cycle while the output is
// not stalled. Each byte passes an input register, then the CRC update and frame
// decode in one pass, with the eight-step bytewise CRC unrolled, into the result
// register. No clearing pass after reset.
module four_way_frame_receiver_crc16 import fwfr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_kind,
    output logic [BYTE_W-1:0]   o_command,
    output logic [ADDR_W-1:0]   o_address,
    output logic [COUNT_W-1:0]  o_param_count,
    output logic [BYTE_W-1:0]   o_param_index,
    output logic [BYTE_W-1:0]   o_param_value,
    output logic                o_crc_ok
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_CMD, PH_ADDR_HI, PH_ADDR_LO,
        PH_LEN, PH_PARAM, PH_CRC_HI, PH_CRC_LO
    } t_phase;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    t_phase             r_phase;
    logic [CRC_W-1:0]   r_crc;
    logic [BYTE_W-1:0]  r_command;
    logic [ADDR_W-1:0]  r_address;
    logic [COUNT_W-1:0] r_length;
    logic [BYTE_W-1:0]  r_seen;
    logic [BYTE_W-1:0]  r_crc_hi;

    logic               r_out_valid;
    logic               r_kind;
    logic [BYTE_W-1:0]  r_out_command;
    logic [ADDR_W-1:0]  r_out_address;
    logic [COUNT_W-1:0] r_out_count;
    logic [BYTE_W-1:0]  r_out_index;
    logic [BYTE_W-1:0]  r_out_value;
    logic               r_out_ok;

    logic               out_free;
    logic               proc_go;
    logic               in_take;
    logic [CRC_W-1:0]   crc_in;
    logic [CRC_W-1:0]   crc_next;
    logic [COUNT_W-1:0] seen_inc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_go    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign crc_in     = (r_phase == PH_HUNT) ? '0 : r_crc;
    assign seen_inc   = {1'b0, r_seen} + COUNT_W'(1);

    fwfr_crc16 u_crc (
        .i_crc  (crc_in),
        .i_byte (r_in_byte),
        .o_crc  (crc_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_crc       <= '0;
            r_command   <= '0;
            r_address   <= '0;
            r_length    <= '0;
            r_seen      <= '0;
            r_crc_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (proc_go) begin
                r_out_valid <= (r_phase == PH_PARAM) || (r_phase == PH_CRC_LO);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (proc_go) begin
                case (r_phase)
                    PH_HUNT: begin
                        r_crc <= crc_next;
                        if (r_in_byte == ESCAPE_BYTE) begin
                            r_phase <= PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        r_crc     <= crc_next;
                        r_command <= r_in_byte;
                        r_phase   <= PH_ADDR_HI;
                    end
                    PH_ADDR_HI: begin
                        r_crc                   <= crc_next;
                        r_address[ADDR_W-1 -: BYTE_W] <= r_in_byte;
                        r_phase                 <= PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        r_crc                 <= crc_next;
                        r_address[BYTE_W-1:0] <= r_in_byte;
                        r_phase               <= PH_LEN;
                    end
                    PH_LEN: begin
                        r_crc    <= crc_next;
                        r_length <= (r_in_byte == '0) ? COUNT_W'(256)
                                                      : {1'b0, r_in_byte};
                        r_seen   <= '0;
                        r_phase  <= PH_PARAM;
                    end
                    PH_PARAM: begin
                        r_crc         <= crc_next;
                        r_kind        <= KIND_PARAM;
                        r_out_command <= r_command;
                        r_out_address <= r_address;
                        r_out_count   <= r_length;
                        r_out_index   <= r_seen;
                        r_out_value   <= r_in_byte;
                        r_out_ok      <= 1'b0;
                        if (seen_inc >= r_length) begin
                            r_phase <= PH_CRC_HI;
                        end
                        r_seen <= seen_inc[BYTE_W-1:0];
                    end
                    PH_CRC_HI: begin
                        r_crc_hi <= r_in_byte;
                        r_phase  <= PH_CRC_LO;
                    end
                    default: begin
                        r_kind        <= KIND_END;
                        r_out_command <= r_command;
                        r_out_address <= r_address;
                        r_out_count   <= r_length;
                        r_out_index   <= '0;
                        r_out_value   <= '0;
                        r_out_ok      <= ({r_crc_hi, r_in_byte} == r_crc);
                        r_phase       <= PH_HUNT;
                    end
                endcase
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_command     = r_out_command;
    assign o_address     = r_out_address;
    assign o_param_count = r_out_count;
    assign o_param_index = r_out_index;
    assign o_param_value = r_out_value;
    assign o_crc_ok      = r_out_ok;

endmodule

FILE: design/fwfr_crc16.sv
// Bytewise CRC-16/XMODEM update, MSB first, eight shift steps unrolled.
// Depends on fwfr_pkg.
module fwfr_crc16 import fwfr_pkg::*; (
    input  logic [CRC_W-1:0]  i_crc,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [CRC_W-1:0]  o_crc
);

    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ {i_byte, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

FILE: design/fwfr_checker.sv
// Port-level checks for the four-way frame receiver, bound to the top level.
// Depends on fwfr_pkg.
module fwfr_checker import fwfr_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic [BYTE_W-1:0]   i_rx_byte,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_kind,
    input logic [BYTE_W-1:0]   o_command,
    input logic [ADDR_W-1:0]   o_address,
    input logic [COUNT_W-1:0]  o_param_count,
    input logic [BYTE_W-1:0]   o_param_index,
    input logic [BYTE_W-1:0]   o_param_value,
    input logic                o_crc_ok
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_kind) && $stable(o_param_index) && $stable(o_param_value)
            && $stable(o_crc_ok) && $stable(o_address))
        else $error("stalled result item changed");

    a_param_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_PARAM |->
            !o_crc_ok && {1'b0, o_param_index} < o_param_count)
        else $error("parameter item index or flag wrong");

    a_end_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_END |->
            o_param_index == '0 && o_param_value == '0)
        else $error("frame end item carries parameter data");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_param_count != '0 && o_param_count <= COUNT_W'(256))
        else $error("parameter count out of range");

endmodule

bind four_way_frame_receiver_crc16 fwfr_checker u_fwfr_checker (.*);

FILE: bench/four_way_frame_receiver_crc16_test.sv
// Testbench for four_way_frame_receiver_crc16: drives framed byte streams with random
// gaps and output stalls, predicts every parameter and frame-end item, checks in order.
// Depends on fwfr_pkg and the design top level.
module four_way_frame_receiver_crc16_test;
    import fwfr_pkg::*;

    typedef enum logic [2:0] {
        RX_HUNT, RX_CMD, RX_ADDR_HI, RX_ADDR_LO, RX_LEN, RX_PARAM, RX_CRC_HI, RX_CRC_LO
    } t_rx_phase;

    typedef struct {
        logic               kind;
        logic [BYTE_W-1:0]  command;
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  index;
        logic [BYTE_W-1:0]  value;
        logic               crc_ok;
    } t_frame_report;

    typedef logic [BYTE_W-1:0] t_byte_queue[$];

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_rx_byte = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_kind;
    logic [BYTE_W-1:0]  o_command;
    logic [ADDR_W-1:0]  o_address;
    logic [COUNT_W-1:0] o_param_count;
    logic [BYTE_W-1:0]  o_param_index;
    logic [BYTE_W-1:0]  o_param_value;
    logic               o_crc_ok;

    // receiver state mirror
    t_rx_phase          rx_phase = RX_HUNT;
    logic [CRC_W-1:0]   crc_acc = '0;
    logic [BYTE_W-1:0]  cur_cmd = '0;
    logic [ADDR_W-1:0]  cur_addr = '0;
    logic [COUNT_W-1:0] cur_len = '0;
    logic [BYTE_W-1:0]  param_seen = '0;
    logic [BYTE_W-1:0]  crc_hi_byte = '0;

    t_frame_report      pending_reports[$];
    t_frame_report      oldest_report;
    int                 err_count = 0;
    int                 frame_items = 0;
    bit                 no_gaps = 1'b0;

    four_way_frame_receiver_crc16 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_command     (o_command),
        .o_address     (o_address),
        .o_param_count (o_param_count),
        .o_param_index (o_param_index),
        .o_param_value (o_param_value),
        .o_crc_ok      (o_crc_ok)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    function automatic t_frame_report make_report(input logic kind, input logic [7:0] idx,
                                                  input logic [7:0] val, input logic ok);
        t_frame_report r;
        r.kind    = kind;
        r.command = cur_cmd;
        r.address = cur_addr;
        r.count   = cur_len;
        r.index   = idx;
        r.value   = val;
        r.crc_ok  = ok;
        return r;
    endfunction

    task automatic advance_receiver(input logic [BYTE_W-1:0] b);
        logic [COUNT_W-1:0] next_seen;
        case (rx_phase)
            RX_HUNT: begin
                crc_acc = crc16_next('0, b);
                if (b == ESCAPE_BYTE) rx_phase = RX_CMD;
            end
            RX_CMD: begin
                crc_acc  = crc16_next(crc_acc, b);
                cur_cmd  = b;
                rx_phase = RX_ADDR_HI;
            end
            RX_ADDR_HI: begin
                crc_acc  = crc16_next(crc_acc, b);
                cur_addr = {b, cur_addr[7:0]};
                rx_phase = RX_ADDR_LO;
            end
            RX_ADDR_LO: begin
                crc_acc  = crc16_next(crc_acc, b);
                cur_addr = {cur_addr[15:8], b};
                rx_phase = RX_LEN;
            end
            RX_LEN: begin
                crc_acc    = crc16_next(crc_acc, b);
                cur_len    = (b == 0) ? 9'd256 : {1'b0, b};
                param_seen = '0;
                rx_phase   = RX_PARAM;
            end
            RX_PARAM: begin
                crc_acc = crc16_next(crc_acc, b);
                pending_reports.push_back(make_report(KIND_PARAM, param_seen, b, 1'b0));
                next_seen = {1'b0, param_seen} + 9'd1;
                if (next_seen >= cur_len) rx_phase = RX_CRC_HI;
                param_seen = next_seen[7:0];
            end
            RX_CRC_HI: begin
                crc_hi_byte = b;
                rx_phase    = RX_CRC_LO;
            end
            default: begin
                pending_reports.push_back(make_report(KIND_END, '0, '0,
                                                      {crc_hi_byte, b} == crc_acc));
                rx_phase = RX_HUNT;
            end
        endcase
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!no_gaps) begin
            while ($urandom_range(99) < 33) begin
                i_in_valid <= 1'b0;
                i_rx_byte  <= 8'($urandom);
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        advance_receiver(b);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] addr,
                              input logic [7:0] len_byte, input t_byte_queue params,
                              input logic [15:0] crc_flip);
        t_byte_queue      bytes;
        logic [CRC_W-1:0] crc;
        bytes.push_back(ESCAPE_BYTE);
        bytes.push_back(cmd);
        bytes.push_back(addr[15:8]);
        bytes.push_back(addr[7:0]);
        bytes.push_back(len_byte);
        foreach (params[i]) bytes.push_back(params[i]);
        crc = '0;
        foreach (bytes[i]) crc = crc16_next(crc, bytes[i]);
        crc ^= crc_flip;
        bytes.push_back(crc[15:8]);
        bytes.push_back(crc[7:0]);
        foreach (bytes[i]) send_byte(bytes[i]);
        frame_items += bytes.size();
    endtask

    task automatic send_random_frame(input int n);
        t_byte_queue params;
        logic [15:0] flip;
        for (int i = 0; i < n; i++) begin
            params.push_back(($urandom_range(9) == 0) ? ESCAPE_BYTE : 8'($urandom));
        end
        flip = ($urandom_range(7) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
        send_frame(8'($urandom), 16'($urandom), 8'(n), params, flip);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 95) return $urandom_range(9, 40);
        return $urandom_range(41, 255);
    endfunction

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom);
            if (b == ESCAPE_BYTE) b ^= 8'h01;
            send_byte(b);
        end
    endtask

    task automatic test_directed();
        t_byte_queue p;
        send_byte(8'h00);
        send_byte(8'hFF);
        p = {8'hFF};
        send_frame(8'h00, 16'hFFFF, 8'd1, p, 16'h0000);
        // escape value inside a frame is plain data; bad CRC
        p = {ESCAPE_BYTE, 8'h00};
        send_frame(8'hFF, 16'h0000, 8'd2, p, 16'h0001);
    endtask

    task automatic test_drain_pause();
        send_random_frame($urandom_range(1, 6));
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        send_random_frame($urandom_range(1, 6));
    endtask

    task automatic test_zero_length();
        send_random_frame(256);
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        while (frame_items < 600) begin
            if ($urandom_range(7) == 0) send_noise();
            send_random_frame(pick_length());
        end
        send_random_frame(255);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_frames();
        while (frame_items < 1550) begin
            if ($urandom_range(7) == 0) send_noise();
            send_random_frame(pick_length());
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= no_gaps ? 1'b0 : ($urandom_range(99) < 33);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $error("result with no item expected");
                err_count++;
            end else begin
                oldest_report = pending_reports.pop_front();
                check_field("kind", oldest_report.kind, o_kind);
                check_field("command", oldest_report.command, o_command);
                check_field("address", oldest_report.address, o_address);
                check_field("param_count", oldest_report.count, o_param_count);
                check_field("param_index", oldest_report.index, o_param_index);
                check_field("param_value", oldest_report.value, o_param_value);
                check_field("crc_ok", oldest_report.crc_ok, o_crc_ok);
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_drain_pause();
        test_zero_length();
        test_back_to_back();
        test_random_frames();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("four_way_frame_receiver_crc16_test: done, clean");
        end else begin
            $display("four_way_frame_receiver_crc16_test: done, errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("four_way_frame_receiver_crc16_test: done, errors");
        $finish;
    end

endmodule
